### src/quaternion_slerp_macros.svh
// Assertion macros shared by the slerp checker.
`ifndef QUATERNION_SLERP_MACROS_SVH
`define QUATERNION_SLERP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well.
`define QS_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### src/qs_pkg.sv
// Types and constants shared by the quaternion slerp pipeline.
package qs_pkg;

    localparam int FRAC     = 14;           // fraction bits of Q2.14
    localparam int QW       = FRAC + 2;     // quaternion part width
    localparam int TW       = FRAC + 1;     // blend width
    localparam int ONE      = 1 << FRAC;    // 1.0
    localparam int ITER     = 16;           // CORDIC steps
    localparam int ANG_BITS = 30;           // angle and CORDIC scale, Q30
    localparam int XW       = 33;           // CORDIC x/y width
    localparam int ZW       = 34;           // rotation CORDIC angle width
    localparam int NW       = 49;           // divider numerator magnitude width
    localparam int DW       = 32;           // divider denominator width
    localparam int QB       = 15;           // quotient bits produced
    localparam int L_DIV    = QB + 3;       // divider latency

    // Pipeline stage numbers (stage 1 is the input register)
    localparam int S_L     = 4;
    localparam int S_SN    = S_L + FRAC + 1;
    localparam int S_M     = 6 + QW;
    localparam int S_ANG   = S_SN + ITER;
    localparam int S_Z     = S_ANG + 2;
    localparam int S_Y     = S_Z + ITER;
    localparam int S_SUM   = S_Y + 2;
    localparam int S_DIN   = S_Y + 3;
    localparam int S_DOUT  = S_DIN + L_DIV;
    localparam int S_OUT   = S_DOUT + 1;

    // atan(2^-n) in Q30, rounded to nearest
    localparam logic signed [31:0] ATAN_TAB [32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0
    };

    typedef logic signed [QW-1:0] t_qs_part;

    typedef struct packed {
        logic signed [QW-1:0] a_i;
        logic signed [QW-1:0] a_j;
        logic signed [QW-1:0] a_k;
        logic signed [QW-1:0] a_real;
        logic signed [QW-1:0] b_i;
        logic signed [QW-1:0] b_j;
        logic signed [QW-1:0] b_k;
        logic signed [QW-1:0] b_real;
        logic [TW-1:0]        blend;
    } t_qs_in;

    typedef struct packed {
        logic signed [QW-1:0] out_i;
        logic signed [QW-1:0] out_j;
        logic signed [QW-1:0] out_k;
        logic signed [QW-1:0] out_real;
        logic                 used_linear;
    } t_qs_out;

    // Divider request: sign, zero override, magnitude and divisor
    typedef struct packed {
        logic          neg;
        logic          zero;
        logic [NW-1:0] mag;
        logic [DW-1:0] den;
    } t_qs_div_in;

endpackage

### src/qs_delay.sv
// Enabled shift line that keeps side data aligned with the pipeline.
module qs_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    // Shift one tap per advancing cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

### src/qs_sqrt.sv
// Pipelined integer square root, one root bit per stage (floor).
module qs_sqrt #(
    parameter int IN_W = 32
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [IN_W-1:0]     i_d,
    output logic [IN_W/2-1:0]   o_q
);

    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 3;

    logic [IN_W-1:0]  r_dat  [OUT_W];
    logic [RW-1:0]    r_rem  [OUT_W];
    logic [OUT_W-1:0] r_root [OUT_W];

    for (genvar s = 0; s < OUT_W; s++) begin : g_stage
        logic [IN_W-1:0]  w_dat;
        logic [RW-1:0]    w_rem;
        logic [OUT_W-1:0] w_root;
        logic [RW-1:0]    w_cur;
        logic [RW-1:0]    w_trial;

        if (s == 0) begin : g_first
            assign w_dat  = i_d;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_dat  = r_dat[s-1];
            assign w_rem  = r_rem[s-1];
            assign w_root = r_root[s-1];
        end

        // Bring down the next bit pair and try root*4+1
        assign w_cur   = {w_rem[RW-3:0], w_dat[IN_W-1 -: 2]};
        assign w_trial = RW'({w_root, 2'b01});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dat[s] <= w_dat << 2;
                if (w_cur >= w_trial) begin
                    r_rem[s]  <= w_cur - w_trial;
                    r_root[s] <= {w_root[OUT_W-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= w_cur;
                    r_root[s] <= {w_root[OUT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_q = r_root[OUT_W-1];

endmodule

### src/qs_cordic_vec.sv
// Vectoring CORDIC pipeline: angle of the vector (x, y), Q30 radians.
module qs_cordic_vec import qs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    output logic signed [XW-1:0] o_z
);

    logic signed [XW-1:0] r_x [ITER];
    logic signed [XW-1:0] r_y [ITER];
    logic signed [XW-1:0] r_z [ITER];

    for (genvar n = 0; n < ITER; n++) begin : g_step
        logic signed [XW-1:0] w_x;
        logic signed [XW-1:0] w_y;
        logic signed [XW-1:0] w_z;
        logic signed [XW-1:0] w_xs;
        logic signed [XW-1:0] w_ys;
        logic signed [XW-1:0] w_at;

        if (n == 0) begin : g_first
            assign w_x = i_x;
            assign w_y = i_y;
            assign w_z = '0;
        end else begin : g_next
            assign w_x = r_x[n-1];
            assign w_y = r_y[n-1];
            assign w_z = r_z[n-1];
        end

        assign w_xs = w_x >>> n;
        assign w_ys = w_y >>> n;
        assign w_at = XW'(ATAN_TAB[n]);

        // Rotate toward the x axis, accumulating the angle
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_y > 0) begin
                    r_x[n] <= w_x + w_ys;
                    r_y[n] <= w_y - w_xs;
                    r_z[n] <= w_z + w_at;
                end else begin
                    r_x[n] <= w_x - w_ys;
                    r_y[n] <= w_y + w_xs;
                    r_z[n] <= w_z - w_at;
                end
            end
        end
    end

    assign o_z = r_z[ITER-1];

endmodule

### src/qs_cordic_rot.sv
// Rotation CORDIC pipeline: gain-scaled sine of a Q30 angle.
module qs_cordic_rot import qs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [ZW-1:0] i_z,
    output logic signed [XW-1:0] o_y
);

    localparam logic signed [XW-1:0] X_INIT = XW'(1 << ANG_BITS);

    logic signed [XW-1:0] r_x [ITER];
    logic signed [XW-1:0] r_y [ITER];
    logic signed [ZW-1:0] r_z [ITER];

    for (genvar n = 0; n < ITER; n++) begin : g_step
        logic signed [XW-1:0] w_x;
        logic signed [XW-1:0] w_y;
        logic signed [ZW-1:0] w_z;
        logic signed [XW-1:0] w_xs;
        logic signed [XW-1:0] w_ys;
        logic signed [ZW-1:0] w_at;

        if (n == 0) begin : g_first
            assign w_x = X_INIT;
            assign w_y = '0;
            assign w_z = i_z;
        end else begin : g_next
            assign w_x = r_x[n-1];
            assign w_y = r_y[n-1];
            assign w_z = r_z[n-1];
        end

        assign w_xs = w_x >>> n;
        assign w_ys = w_y >>> n;
        assign w_at = ZW'(ATAN_TAB[n]);

        // Drive the residual angle toward zero
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_z >= 0) begin
                    r_x[n] <= w_x - w_ys;
                    r_y[n] <= w_y + w_xs;
                    r_z[n] <= w_z - w_at;
                end else begin
                    r_x[n] <= w_x + w_ys;
                    r_y[n] <= w_y - w_xs;
                    r_z[n] <= w_z + w_at;
                end
            end
        end
    end

    assign o_y = r_y[ITER-1];

endmodule

### src/qs_div.sv
// Pipelined rounding divider with saturation to +-1.0, one quotient bit per stage.
module qs_div import qs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  t_qs_div_in           i_req,
    output logic signed [QW-1:0] o_q
);

    // Stage A: add half the divisor for round half away from zero
    logic          r_a_neg;
    logic          r_a_zero;
    logic [NW:0]   r_a_n;
    logic [DW-1:0] r_a_den;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_neg  <= i_req.neg;
            r_a_zero <= i_req.zero;
            r_a_n    <= (NW+1)'(i_req.mag) + (NW+1)'(i_req.den >> 1);
            r_a_den  <= i_req.den;
        end
    end

    // Stage B: quotient overflow check and starting remainder
    logic          r_b_neg;
    logic          r_b_zero;
    logic          r_b_ovf;
    logic [DW-1:0] r_b_rem;
    logic [QB-1:0] r_b_low;
    logic [DW-1:0] r_b_den;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_neg  <= r_a_neg;
            r_b_zero <= r_a_zero;
            r_b_ovf  <= r_a_n[NW:QB] >= (NW+1-QB)'(r_a_den);
            r_b_rem  <= r_a_n[QB+DW-1:QB];
            r_b_low  <= r_a_n[QB-1:0];
            r_b_den  <= r_a_den;
        end
    end

    // Restoring steps
    logic          r_s_neg  [QB];
    logic          r_s_zero [QB];
    logic          r_s_ovf  [QB];
    logic [DW-1:0] r_s_rem  [QB];
    logic [QB-1:0] r_s_low  [QB];
    logic [QB-1:0] r_s_q    [QB];
    logic [DW-1:0] r_s_den  [QB];

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic          w_neg;
        logic          w_zero;
        logic          w_ovf;
        logic [DW-1:0] w_rem;
        logic [QB-1:0] w_low;
        logic [QB-1:0] w_q;
        logic [DW-1:0] w_den;
        logic [DW:0]   w_cur;
        logic [DW:0]   w_diff;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_neg  = r_b_neg;
            assign w_zero = r_b_zero;
            assign w_ovf  = r_b_ovf;
            assign w_rem  = r_b_rem;
            assign w_low  = r_b_low;
            assign w_q    = '0;
            assign w_den  = r_b_den;
        end else begin : g_next
            assign w_neg  = r_s_neg[k-1];
            assign w_zero = r_s_zero[k-1];
            assign w_ovf  = r_s_ovf[k-1];
            assign w_rem  = r_s_rem[k-1];
            assign w_low  = r_s_low[k-1];
            assign w_q    = r_s_q[k-1];
            assign w_den  = r_s_den[k-1];
        end

        assign w_cur  = {w_rem, w_low[QB-1]};
        assign w_diff = w_cur - {1'b0, w_den};
        assign w_ge   = w_cur >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s_neg[k]  <= w_neg;
                r_s_zero[k] <= w_zero;
                r_s_ovf[k]  <= w_ovf;
                r_s_rem[k]  <= w_ge ? w_diff[DW-1:0] : w_cur[DW-1:0];
                r_s_low[k]  <= w_low << 1;
                r_s_q[k]    <= {w_q[QB-2:0], w_ge};
                r_s_den[k]  <= w_den;
            end
        end
    end

    // Final stage: clamp to 1.0 and apply the sign, or force zero
    logic [QB-1:0]        w_qf;
    logic [QW-1:0]        w_mag;
    logic signed [QW-1:0] r_q;

    assign w_qf  = r_s_q[QB-1];
    assign w_mag = (r_s_ovf[QB-1] || (w_qf > QB'(ONE))) ? QW'(ONE) : QW'(w_qf);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_s_zero[QB-1]) begin
                r_q <= '0;
            end else if (r_s_neg[QB-1]) begin
                r_q <= -$signed(w_mag);
            end else begin
                r_q <= $signed(w_mag);
            end
        end
    end

    assign o_q = r_q;

endmodule

### src/quaternion_slerp.sv
// Quaternion slerp: fully pipelined, one transaction per cycle unless the output stalls.
//
// Input channel i_valid / o_ready carries two Q2.14 quaternions and a blend
// fraction; output channel o_valid / i_ready carries the interpolated
// quaternion and a flag set when the normalized linear blend was used.
// Both branches (slerp and normalized lerp) run side by side; a shared bank
// of four pipelined dividers finishes whichever one the dot product picks.
// The path from acceptance to o_valid runs through the two CORDIC
// pipelines (16 stages each), the 15-stage square root and the 18-stage
// divider; a new transaction can enter every cycle while nothing stalls.
// All stages advance together while the output register is empty or being
// taken; when the receiver holds i_ready low with a result waiting, the whole
// pipeline holds and o_ready drops, so nothing is lost or repeated.
// A synchronous reset clears all valid bits; data registers are not reset.
module quaternion_slerp import qs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_qs_in  i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_qs_out o_data
);

    localparam int DOT_W = 20;
    localparam int LIM   = (1 << (FRAC + 1)) - 1;
    localparam int RAD_W = 2 * FRAC + 1;
    localparam int PW    = XW + QW;

    logic w_adv;
    logic [S_OUT-1:0] r_vld;

    // Global advance: output empty or being taken
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[S_OUT-1];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[S_OUT-2:0], i_valid};
        end
    end

    // Stage 1: input register, blend clamped to 1.0
    t_qs_part r1_a [4];
    t_qs_part r1_b [4];
    logic [TW-1:0] r1_t;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_a[0] <= i_data.a_i;
            r1_a[1] <= i_data.a_j;
            r1_a[2] <= i_data.a_k;
            r1_a[3] <= i_data.a_real;
            r1_b[0] <= i_data.b_i;
            r1_b[1] <= i_data.b_j;
            r1_b[2] <= i_data.b_k;
            r1_b[3] <= i_data.b_real;
            r1_t    <= (i_data.blend > TW'(ONE)) ? TW'(ONE) : i_data.blend;
        end
    end

    // Stage 2: part products and differences
    logic signed [2*QW-1:0] r2_p   [4];
    logic signed [QW:0]     r2_dif [4];
    t_qs_part               r2_a   [4];
    logic [TW-1:0]          r2_t;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 4; c++) begin
                r2_p[c]   <= r1_a[c] * r1_b[c];
                r2_dif[c] <= (QW+1)'(r1_b[c]) - (QW+1)'(r1_a[c]);
                r2_a[c]   <= r1_a[c];
            end
            r2_t <= r1_t;
        end
    end

    // Stage 3: dot product and blended differences
    logic signed [2*QW-1:0] w_dsum;
    logic signed [2*QW-1:0] w_dsh;
    logic signed [DOT_W-1:0] r3_d;
    logic signed [QW+TW+1:0] r3_lp [4];
    t_qs_part                r3_a  [4];

    assign w_dsum = (r2_p[0] >>> 2) + (r2_p[1] >>> 2) + (r2_p[2] >>> 2) + (r2_p[3] >>> 2);
    assign w_dsh  = w_dsum >>> (FRAC - 2);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_d <= w_dsh[DOT_W-1:0];
            for (int c = 0; c < 4; c++) begin
                r3_lp[c] <= r2_dif[c] * $signed({1'b0, r2_t});
                r3_a[c]  <= r2_a[c];
            end
        end
    end

    // Stage 4: branch select, 1 - d^2, saturated lerp parts
    logic [FRAC-1:0]           w_d14;
    logic signed [QW+TW+1:0]   w_ls   [4];
    logic signed [DOT_W-1:0]   w_lsum [4];
    logic                      r4_lin;
    logic [RAD_W-1:0]          r4_rad;
    t_qs_part                  r4_l   [4];

    assign w_d14 = r3_d[FRAC-1:0];

    for (genvar c = 0; c < 4; c++) begin : g_lerp
        assign w_ls[c]   = r3_lp[c] >>> FRAC;
        assign w_lsum[c] = DOT_W'(r3_a[c]) + w_ls[c][DOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_lin <= !((r3_d > 0) && (r3_d < DOT_W'(ONE)));
            r4_rad <= RAD_W'(1 << (2 * FRAC)) - (RAD_W'(w_d14) * RAD_W'(w_d14));
            for (int c = 0; c < 4; c++) begin
                if (w_lsum[c] > DOT_W'(LIM)) begin
                    r4_l[c] <= QW'(LIM);
                end else if (w_lsum[c] < -DOT_W'(LIM)) begin
                    r4_l[c] <= -QW'(LIM);
                end else begin
                    r4_l[c] <= w_lsum[c][QW-1:0];
                end
            end
        end
    end

    // Stages 5-6: squared length of the lerp
    logic signed [2*QW-1:0] w_sq  [4];
    logic [2*QW-3:0]        r5_lsq [4];
    logic [2*QW-1:0]        r6_sum;

    for (genvar c = 0; c < 4; c++) begin : g_sq
        assign w_sq[c] = r4_l[c] * r4_l[c];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 4; c++) begin
                r5_lsq[c] <= w_sq[c][2*QW-3:0];
            end
            r6_sum <= (2*QW)'(r5_lsq[0]) + (2*QW)'(r5_lsq[1])
                    + (2*QW)'(r5_lsq[2]) + (2*QW)'(r5_lsq[3]);
        end
    end

    // Square roots: sine of the angle and lerp length
    logic [FRAC:0]   w_sn;
    logic [QW-1:0]   w_m;

    qs_sqrt #(.IN_W(RAD_W + 1)) u_sqrt_sin (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   ({1'b0, r4_rad}),
        .o_q   (w_sn)
    );

    qs_sqrt #(.IN_W(2 * QW)) u_sqrt_len (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   (r6_sum),
        .o_q   (w_m)
    );

    // Angle from (d, sin) in Q30
    logic [FRAC-1:0]      w_d_sn;
    logic signed [XW-1:0] w_vx;
    logic signed [XW-1:0] w_vy;
    logic signed [XW-1:0] w_ang;

    qs_delay #(.WIDTH(FRAC), .DEPTH(S_SN - 3)) u_dly_d (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   (w_d14),
        .o_q   (w_d_sn)
    );

    assign w_vx = XW'(w_d_sn) << (ANG_BITS - FRAC);
    assign w_vy = XW'(w_sn) << (ANG_BITS - FRAC);

    qs_cordic_vec u_angle (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_x   (w_vx),
        .i_y   (w_vy),
        .o_z   (w_ang)
    );

    // Split the angle by the blend fraction
    logic [TW-1:0]           w_t_ang;
    logic signed [XW+TW:0]   r_tp;
    logic signed [XW-1:0]    r_ang;
    logic signed [XW+TW:0]   w_ta;
    logic signed [ZW-1:0]    r_za;
    logic signed [ZW-1:0]    r_zb;
    logic signed [ZW-1:0]    r_zs;

    qs_delay #(.WIDTH(TW), .DEPTH(S_ANG - 1)) u_dly_t (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   (r1_t),
        .o_q   (w_t_ang)
    );

    assign w_ta = r_tp >>> FRAC;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tp  <= w_ang * $signed({1'b0, w_t_ang});
            r_ang <= w_ang;
            r_zb  <= ZW'(w_ta);
            r_za  <= ZW'(r_ang) - ZW'(w_ta);
            r_zs  <= ZW'(r_ang);
        end
    end

    // Sines of (1-t)theta, t theta and theta
    logic signed [XW-1:0] w_ya;
    logic signed [XW-1:0] w_yb;
    logic signed [XW-1:0] w_ys;

    qs_cordic_rot u_sin_a (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_z   (r_za),
        .o_y   (w_ya)
    );

    qs_cordic_rot u_sin_b (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_z   (r_zb),
        .o_y   (w_yb)
    );

    qs_cordic_rot u_sin_s (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_z   (r_zs),
        .o_y   (w_ys)
    );

    // Weighted sums of the two inputs
    logic [8*QW-1:0]     w_ab;
    t_qs_part            w_ay [4];
    t_qs_part            w_by [4];
    logic signed [PW-1:0] r_pa  [4];
    logic signed [PW-1:0] r_pb  [4];
    logic signed [PW:0]   r_sum [4];
    logic [DW-1:0]        r_ys;
    logic [DW-1:0]        r_ys2;

    qs_delay #(.WIDTH(8 * QW), .DEPTH(S_Y - 1)) u_dly_ab (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   ({r1_a[0], r1_a[1], r1_a[2], r1_a[3], r1_b[0], r1_b[1], r1_b[2], r1_b[3]}),
        .o_q   (w_ab)
    );

    for (genvar c = 0; c < 4; c++) begin : g_ab
        assign w_ay[c] = w_ab[(7-c)*QW +: QW];
        assign w_by[c] = w_ab[(3-c)*QW +: QW];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 4; c++) begin
                r_pa[c]  <= w_ay[c] * w_ya;
                r_pb[c]  <= w_by[c] * w_yb;
                r_sum[c] <= (PW+1)'(r_pa[c]) + (PW+1)'(r_pb[c]);
            end
            r_ys  <= (w_ys < 1) ? DW'(1) : w_ys[DW-1:0];
            r_ys2 <= r_ys;
        end
    end

    // Lerp side data aligned to the divider input
    logic [4*QW-1:0] w_l_dly;
    t_qs_part        w_l [4];
    logic [QW-1:0]   w_m_dly;
    logic            w_lin_sum;
    logic            w_lin_out;

    qs_delay #(.WIDTH(4 * QW), .DEPTH(S_SUM - S_L)) u_dly_l (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   ({r4_l[0], r4_l[1], r4_l[2], r4_l[3]}),
        .o_q   (w_l_dly)
    );

    qs_delay #(.WIDTH(QW), .DEPTH(S_SUM - S_M)) u_dly_m (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   (w_m),
        .o_q   (w_m_dly)
    );

    qs_delay #(.WIDTH(1), .DEPTH(S_SUM - S_L)) u_dly_lin (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   (r4_lin),
        .o_q   (w_lin_sum)
    );

    qs_delay #(.WIDTH(1), .DEPTH(S_DOUT - S_SUM)) u_dly_flag (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_d   (w_lin_sum),
        .o_q   (w_lin_out)
    );

    for (genvar c = 0; c < 4; c++) begin : g_l
        assign w_l[c] = w_l_dly[(3-c)*QW +: QW];
    end

    // Divider input select: lerp over length, or weighted sum over sin(theta)
    t_qs_div_in           r_req [4];
    logic signed [QW-1:0] w_q   [4];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < 4; c++) begin
                if (w_lin_sum) begin
                    r_req[c].neg  <= w_l[c] < 0;
                    r_req[c].mag  <= NW'(w_l[c] < 0 ? -w_l[c] : w_l[c]) << FRAC;
                    r_req[c].den  <= DW'(w_m_dly);
                    r_req[c].zero <= w_m_dly == '0;
                end else begin
                    r_req[c].neg  <= r_sum[c] < 0;
                    r_req[c].mag  <= NW'(r_sum[c] < 0 ? -r_sum[c] : r_sum[c]);
                    r_req[c].den  <= r_ys2;
                    r_req[c].zero <= 1'b0;
                end
            end
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_div
        qs_div u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_req (r_req[c]),
            .o_q   (w_q[c])
        );
    end

    // Output register
    t_qs_out r_out;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.out_i       <= w_q[0];
            r_out.out_j       <= w_q[1];
            r_out.out_k       <= w_q[2];
            r_out.out_real    <= w_q[3];
            r_out.used_linear <= w_lin_out;
        end
    end

    assign o_data = r_out;

endmodule

### src/qs_check.sv
// Port-level checker for the quaternion slerp block, bound to the top level.
`include "quaternion_slerp_macros.svh"

module qs_check import qs_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    o_valid,
    input logic    i_ready,
    input logic    o_ready,
    input t_qs_out o_data
);

    // Reset empties the pipeline
    `QS_ASSERT_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_valid, "o_valid after reset")

    // A result waiting on a stalled receiver holds
    `QS_ASSERT_NOW(a_hold, i_clk, i_rst_n, o_valid && !i_ready, ##1 (o_valid && $stable(o_data)), "stalled transaction changed")

    // The pipeline stalls exactly when a result waits and i_ready is low
    `QS_ASSERT_NOW(a_stall, i_clk, i_rst_n, 1'b1, o_ready == (!o_valid || i_ready), "ready does not follow the output stall")

    // Every part stays within +-1.0
    `QS_ASSERT_NOW(a_range, i_clk, i_rst_n, o_valid, (o_data.out_i <= ONE) && (o_data.out_i >= -ONE) && (o_data.out_j <= ONE) && (o_data.out_j >= -ONE) && (o_data.out_k <= ONE) && (o_data.out_k >= -ONE) && (o_data.out_real <= ONE) && (o_data.out_real >= -ONE), "result part out of range")

endmodule

bind quaternion_slerp qs_check u_check (.*);
